### src/stdlp_pkg.sv
// shared types, codes and constants for the subtitle dialogue line timing parser
// no dependencies
package stdlp_pkg;

  localparam int unsigned PrefixLen = 9;
  localparam logic [9:0]  PosMax    = 10'd1023;
  localparam logic [32:0] TimeMax   = 33'd2147483647;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_FIELDS = 3'd2,
    PH_TEXT   = 3'd3,
    PH_NOTDLG = 3'd4,
    PH_TRUNC  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOTDLG = 3'd1,
    ST_FEW    = 3'd2,
    ST_BAD    = 3'd3,
    ST_ORDER  = 3'd4
  } status_e;

  // timestamp component being parsed
  localparam logic [2:0] TcHours = 3'd0;
  localparam logic [2:0] TcMins  = 3'd1;
  localparam logic [2:0] TcSecs  = 3'd2;
  localparam logic [2:0] TcCenti = 3'd3;
  localparam logic [2:0] TcDone  = 3'd4;
  localparam logic [2:0] TcFail  = 3'd5;

  // number sub-state
  localparam logic [1:0] NsIdle  = 2'd0;
  localparam logic [1:0] NsSign  = 2'd1;
  localparam logic [1:0] NsDigit = 2'd2;

  localparam logic [1:0] CfgStart = 2'd0;
  localparam logic [1:0] CfgEnd   = 2'd1;
  localparam logic [1:0] CfgText  = 2'd2;

  typedef struct packed {
    logic [7:0] lc;
    logic [3:0] dig;
    logic       is_zero;
    logic       is_ws;
    logic       is_digit;
    logic       is_plus;
    logic       is_comma;
    logic       is_colon;
    logic       is_dot;
    logic       last;
  } tok_t;

  function automatic logic [7:0] tag_char(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h64;
      4'd1:    r = 8'h69;
      4'd2:    r = 8'h61;
      4'd3:    r = 8'h6c;
      4'd4:    r = 8'h6f;
      4'd5:    r = 8'h67;
      4'd6:    r = 8'h75;
      4'd7:    r = 8'h65;
      4'd8:    r = 8'h3a;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### src/stdlp_front.sv
// front end: takes character beats, classifies them and holds them in a two-entry queue
// depends on stdlp_pkg
module stdlp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      char_byte_i,
  input  logic            line_end_i,
  output logic            tok_valid_o,
  output stdlp_pkg::tok_t tok_o,
  input  logic            tok_pop_i
);

  stdlp_pkg::tok_t q_mem_q [2];
  logic            wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  stdlp_pkg::tok_t tok_in;
  logic            wr_en, rd_en;

  always_comb begin
    tok_in.lc       = (char_byte_i >= 8'h41 && char_byte_i <= 8'h5a) ?
                      char_byte_i + 8'd32 : char_byte_i;
    tok_in.dig      = 4'(char_byte_i - 8'h30);
    tok_in.is_zero  = (char_byte_i == 8'h00);
    tok_in.is_ws    = (char_byte_i == 8'h20) || (char_byte_i >= 8'h09 && char_byte_i <= 8'h0d);
    tok_in.is_digit = (char_byte_i >= 8'h30 && char_byte_i <= 8'h39);
    tok_in.is_plus  = (char_byte_i == 8'h2b);
    tok_in.is_comma = (char_byte_i == 8'h2c);
    tok_in.is_colon = (char_byte_i == 8'h3a);
    tok_in.is_dot   = (char_byte_i == 8'h2e);
    tok_in.last     = line_end_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = q_mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = tok_pop_i && tok_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem_q[wr_ptr_q] <= tok_in;
    end
  end

endmodule

### src/stdlp_back.sv
// back end: line parser, timestamp evaluation pipeline and result queue
// depends on stdlp_pkg
module stdlp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  input  stdlp_pkg::tok_t tok_i,
  output logic            tok_pop_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [3:0]      cfg_val_i,
  output logic            empty,
  input  logic            pop,
  output logic [2:0]      status_o,
  output logic [30:0]     start_ms_o,
  output logic [30:0]     end_ms_o,
  output logic [9:0]      text_offset_o
);

  typedef struct packed {
    logic             commit;
    logic             fin;
    logic             is_start;
    logic             is_end;
    logic             syn_ok;
    logic [9:0]       h;
    logic [6:0]       m;
    logic [6:0]       s;
    logic [6:0]       c;
    stdlp_pkg::phase_e cls;
    logic [9:0]       ts;
  } ev_t;

  typedef struct packed {
    logic             commit;
    logic             fin;
    logic             is_start;
    logic             is_end;
    logic             bad;
    logic [21:0]      hs;
    logic [10:0]      c10;
    stdlp_pkg::phase_e cls;
    logic [9:0]       ts;
  } ev2_t;

  typedef struct packed {
    logic             commit;
    logic             fin;
    logic             is_start;
    logic             is_end;
    logic             bad;
    logic [32:0]      t;
    stdlp_pkg::phase_e cls;
    logic [9:0]       ts;
  } ev3_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] start_ms;
    logic [30:0] end_ms;
    logic [9:0]  off;
  } res_t;

  // configuration
  logic [3:0] start_col_q, end_col_q, text_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_col_q <= 4'd1;
      end_col_q   <= 4'd2;
      text_col_q  <= 4'd9;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stdlp_pkg::CfgStart: start_col_q <= cfg_val_i;
        stdlp_pkg::CfgEnd:   end_col_q   <= cfg_val_i;
        stdlp_pkg::CfgText:  text_col_q  <= cfg_val_i;
        default: ;
      endcase
    end
  end

  // parser state
  stdlp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  pc_q, pc_d, fi_q, fi_d;
  logic [2:0]  tc_q, tc_d;
  logic [1:0]  ns_q, ns_d;
  logic [9:0]  h_q, h_d;
  logic [6:0]  m_q, m_d, s_q, s_d, c_q, c_d;
  logic [9:0]  pos_q, pos_d, ts_q, ts_d;
  ev_t         ev;

  logic        r1_v_q, r2_v_q, r3_v_q;
  ev_t         r1_q;
  ev2_t        r2_q;
  ev3_t        r3_q;
  logic        en, ofull;

  always_comb begin
    logic [9:0]  pos_nx;
    logic [13:0] hv;
    logic [10:0] av;
    logic [6:0]  acc7;
    phase_d = phase_q;
    pc_d    = pc_q;
    fi_d    = fi_q;
    tc_d    = tc_q;
    ns_d    = ns_q;
    h_d     = h_q;
    m_d     = m_q;
    s_d     = s_q;
    c_d     = c_q;
    ts_d    = ts_q;
    pos_nx  = (pos_q < stdlp_pkg::PosMax) ? pos_q + 10'd1 : stdlp_pkg::PosMax;
    pos_d   = pos_nx;
    hv      = 14'(h_q) * 14'd10 + 14'(tok_i.dig);
    case (tc_q)
      stdlp_pkg::TcMins: acc7 = m_q;
      stdlp_pkg::TcSecs: acc7 = s_q;
      default:           acc7 = c_q;
    endcase
    av = 11'(acc7) * 11'd10 + 11'(tok_i.dig);
    ev = '0;
    ev.h        = h_q;
    ev.m        = m_q;
    ev.s        = s_q;
    ev.c        = c_q;
    ev.is_start = (fi_q == start_col_q);
    ev.is_end   = (fi_q == end_col_q);
    ev.syn_ok   = (tc_q == stdlp_pkg::TcDone) ||
                  (tc_q == stdlp_pkg::TcCenti && ns_q == stdlp_pkg::NsDigit);

    if (phase_d == stdlp_pkg::PH_LEAD) begin
      if (tok_i.is_zero) phase_d = stdlp_pkg::PH_NOTDLG;
      else if (!tok_i.is_ws) phase_d = stdlp_pkg::PH_PREFIX;
    end
    if (phase_d == stdlp_pkg::PH_PREFIX) begin
      if (pc_q < 4'(stdlp_pkg::PrefixLen) && tok_i.lc == stdlp_pkg::tag_char(pc_q)) begin
        pc_d = pc_q + 4'd1;
        if (pc_d == 4'(stdlp_pkg::PrefixLen)) begin
          fi_d = 4'd0;
          tc_d = stdlp_pkg::TcHours;
          ns_d = stdlp_pkg::NsIdle;
          h_d = '0; m_d = '0; s_d = '0; c_d = '0;
          if (text_col_q == 4'd0) begin
            phase_d = stdlp_pkg::PH_TEXT;
            ts_d    = pos_nx;
          end else begin
            phase_d = stdlp_pkg::PH_FIELDS;
          end
        end
      end else begin
        phase_d = stdlp_pkg::PH_NOTDLG;
      end
    end else if (phase_d == stdlp_pkg::PH_FIELDS) begin
      if (tok_i.is_zero) begin
        phase_d = stdlp_pkg::PH_TRUNC;
      end else if (tok_i.is_comma) begin
        ev.commit = 1'b1;
        fi_d = fi_q + 4'd1;
        if (fi_d >= text_col_q) begin
          phase_d = stdlp_pkg::PH_TEXT;
          ts_d    = pos_nx;
        end else begin
          tc_d = stdlp_pkg::TcHours;
          ns_d = stdlp_pkg::NsIdle;
          h_d = '0; m_d = '0; s_d = '0; c_d = '0;
        end
      end else if (tc_q < stdlp_pkg::TcDone) begin
        if (tok_i.is_digit && (ns_q != stdlp_pkg::NsIdle || !tok_i.is_ws)) begin
          ns_d = stdlp_pkg::NsDigit;
          case (tc_q)
            stdlp_pkg::TcHours: h_d = (hv > 14'd1023) ? 10'd1023 : hv[9:0];
            stdlp_pkg::TcMins:  m_d = (av > 11'd127) ? 7'd127 : av[6:0];
            stdlp_pkg::TcSecs:  s_d = (av > 11'd127) ? 7'd127 : av[6:0];
            default:            c_d = (av > 11'd127) ? 7'd127 : av[6:0];
          endcase
        end else if (ns_q == stdlp_pkg::NsIdle) begin
          if (tok_i.is_plus) ns_d = stdlp_pkg::NsSign;
          else if (!tok_i.is_ws) tc_d = stdlp_pkg::TcFail;
        end else if (ns_q == stdlp_pkg::NsSign) begin
          tc_d = stdlp_pkg::TcFail;
        end else if (tc_q == stdlp_pkg::TcCenti) begin
          tc_d = stdlp_pkg::TcDone;
        end else if ((tc_q == stdlp_pkg::TcSecs) ? tok_i.is_dot : tok_i.is_colon) begin
          tc_d = tc_q + 3'd1;
          ns_d = stdlp_pkg::NsIdle;
        end else begin
          tc_d = stdlp_pkg::TcFail;
        end
      end
    end
    ev.fin = tok_i.last;
    ev.cls = phase_d;
    ev.ts  = ts_d;
    if (tok_i.last) begin
      phase_d = stdlp_pkg::PH_LEAD;
      pc_d = '0; fi_d = '0;
      tc_d = stdlp_pkg::TcHours;
      ns_d = stdlp_pkg::NsIdle;
      h_d = '0; m_d = '0; s_d = '0; c_d = '0;
      pos_d = '0; ts_d = '0;
    end
  end

  assign en        = !(r3_v_q && r3_q.fin && ofull);
  assign tok_pop_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= stdlp_pkg::PH_LEAD;
      pc_q <= '0; fi_q <= '0;
      tc_q <= stdlp_pkg::TcHours;
      ns_q <= stdlp_pkg::NsIdle;
      h_q <= '0; m_q <= '0; s_q <= '0; c_q <= '0;
      pos_q <= '0; ts_q <= '0;
    end else if (en && tok_valid_i) begin
      phase_q <= phase_d;
      pc_q <= pc_d; fi_q <= fi_d;
      tc_q <= tc_d; ns_q <= ns_d;
      h_q <= h_d; m_q <= m_d; s_q <= s_d; c_q <= c_d;
      pos_q <= pos_d; ts_q <= ts_d;
    end
  end

  // evaluation pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
    end else if (en) begin
      r1_v_q <= tok_valid_i && (ev.commit || ev.fin);
      r2_v_q <= r1_v_q;
      r3_v_q <= r2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q <= ev;
      r2_q.commit   <= r1_q.commit;
      r2_q.fin      <= r1_q.fin;
      r2_q.is_start <= r1_q.is_start;
      r2_q.is_end   <= r1_q.is_end;
      r2_q.bad      <= !r1_q.syn_ok || (r1_q.m >= 7'd60) || (r1_q.s >= 7'd60) ||
                       (r1_q.c >= 7'd100);
      r2_q.hs       <= 22'(r1_q.h) * 22'd3600 + 22'(r1_q.m) * 22'd60 + 22'(r1_q.s);
      r2_q.c10      <= 11'(r1_q.c) * 11'd10;
      r2_q.cls      <= r1_q.cls;
      r2_q.ts       <= r1_q.ts;
      r3_q.commit   <= r2_q.commit;
      r3_q.fin      <= r2_q.fin;
      r3_q.is_start <= r2_q.is_start;
      r3_q.is_end   <= r2_q.is_end;
      r3_q.bad      <= r2_q.bad;
      r3_q.t        <= 33'(r2_q.hs) * 33'd1000 + 33'(r2_q.c10);
      r3_q.cls      <= r2_q.cls;
      r3_q.ts       <= r2_q.ts;
    end
  end

  // time registers and result
  logic        sv_q, ev_q, sv_n, ev_n, v_ok;
  logic [30:0] st_q, et_q, st_n, et_n;
  res_t        res;

  always_comb begin
    v_ok = !r3_q.bad && (r3_q.t <= stdlp_pkg::TimeMax);
    sv_n = sv_q; st_n = st_q;
    ev_n = ev_q; et_n = et_q;
    if (r3_q.commit && r3_q.is_start) begin
      sv_n = v_ok; st_n = r3_q.t[30:0];
    end
    if (r3_q.commit && r3_q.is_end) begin
      ev_n = v_ok; et_n = r3_q.t[30:0];
    end
    res = '0;
    if (r3_q.cls == stdlp_pkg::PH_LEAD || r3_q.cls == stdlp_pkg::PH_PREFIX ||
        r3_q.cls == stdlp_pkg::PH_NOTDLG) begin
      res.status = stdlp_pkg::ST_NOTDLG;
    end else if (r3_q.cls != stdlp_pkg::PH_TEXT) begin
      res.status = stdlp_pkg::ST_FEW;
    end else if (!sv_n || !ev_n) begin
      res.status = stdlp_pkg::ST_BAD;
    end else if (et_n <= st_n) begin
      res.status = stdlp_pkg::ST_ORDER;
    end else begin
      res.status   = stdlp_pkg::ST_OK;
      res.start_ms = st_n;
      res.end_ms   = et_n;
      res.off      = r3_q.ts;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
      ev_q <= 1'b0;
    end else if (en && r3_v_q) begin
      sv_q <= r3_q.fin ? 1'b0 : sv_n;
      ev_q <= r3_q.fin ? 1'b0 : ev_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && r3_v_q) begin
      st_q <= st_n;
      et_q <= et_n;
    end
  end

  // result queue
  res_t       o_mem_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q;
  logic       opush, opop;

  assign ofull  = (ocnt_q == 2'd2);
  assign empty  = (ocnt_q == 2'd0);
  assign opush  = r3_v_q && r3_q.fin && !ofull;
  assign opop   = pop && !empty;

  assign status_o      = o_mem_q[ord_q].status;
  assign start_ms_o    = o_mem_q[ord_q].start_ms;
  assign end_ms_o      = o_mem_q[ord_q].end_ms;
  assign text_offset_o = o_mem_q[ord_q].off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (opush) owr_q <= !owr_q;
      if (opop) ord_q <= !ord_q;
      ocnt_q <= ocnt_q + {1'b0, opush} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      o_mem_q[owr_q] <= res;
    end
  end

endmodule

### src/subtitle_dialogue_line_timing_parser.sv
// top level of the subtitle dialogue line timing parser: character beats in, line results out
// depends on stdlp_pkg, stdlp_front and stdlp_back
// throughput: one character per cycle, set by the single-cycle parser step in the back end,
// except while a finished line waits on a full result queue; a line result passes through the
// front queue, parser, two timestamp multiply stages and result queue
// reset: asynchronous active low; clears queues, parser state and registers to defaults
module subtitle_dialogue_line_timing_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte_i,
  input  logic        line_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [30:0] start_ms_o,
  output logic [30:0] end_ms_o,
  output logic [9:0]  text_offset_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  logic            tok_valid, tok_pop;
  stdlp_pkg::tok_t tok;

  assign cfg_ready_o = 1'b1;

  stdlp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .char_byte_i (char_byte_i),
    .line_end_i  (line_end_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  stdlp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_valid_i   (tok_valid),
    .tok_i         (tok),
    .tok_pop_o     (tok_pop),
    .cfg_we_i      (cfg_valid_i),
    .cfg_idx_i     (cfg_index_i),
    .cfg_val_i     (cfg_data_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .start_ms_o    (start_ms_o),
    .end_ms_o      (end_ms_o),
    .text_offset_o (text_offset_o)
  );

endmodule
